@@ rtl/vnms_pkg.sv @@
// Shared types and constants for the vector norm maximum selector.
// Used by vnms_ctrl, vnms_datapath and vector_norm_max_select_core.
package vnms_pkg;

    localparam int ELEM_W    = 16;   // one vector element
    localparam int ROW_W     = 21;   // one row of A*x
    localparam int VALUE_W   = 37;   // norm value and running maximum
    localparam int MASK_W    = 16;   // tie mask bits
    localparam int COUNT_W   = 5;    // vector index and tie count
    localparam int STEP_W    = 4;    // multiply step counter
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - MASK_W - COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd31;

    // norm_kind codes; the spare code runs as the quadratic form
    localparam logic [1:0] NORM_MAXABS = 2'd0;
    localparam logic [1:0] NORM_SUMSQ  = 2'd1;
    localparam logic [1:0] NORM_FORM   = 2'd2;
    localparam logic [1:0] NORM_SPARE  = 2'd3;

    // multiply steps per kind
    localparam logic [STEP_W-1:0] STEPS_MAXABS = 4'd0;
    localparam logic [STEP_W-1:0] STEPS_SUMSQ  = 4'd3;
    localparam logic [STEP_W-1:0] STEPS_FORM   = 4'd12;

    typedef enum logic [1:0] {
        A_COEF,
        A_ROW,
        A_ELEM
    } a_src_t;

    typedef enum logic [1:0] {
        DST_ROW0,
        DST_ROW1,
        DST_ROW2,
        DST_VAL
    } acc_dst_t;

    typedef struct packed {
        logic        load;        // capture a vector, clear accumulators
        logic        mul_en;      // issue one multiply
        a_src_t      a_src;
        logic [3:0]  coef_idx;    // matrix entry, row-major
        logic [1:0]  a_row;
        logic [1:0]  b_elem;
        acc_dst_t    dst;         // where the product lands
        logic        abs_en;      // largest absolute element into value
        logic        check_sign;  // negative value is no candidate
        logic        update;      // fold value into running maximum
        logic        emit;        // hand result out, clear the set
    } dp_cmd_t;

    // fixed matrix 1..9, row-major
    function automatic logic signed [ROW_W-1:0] form_coef(input logic [3:0] idx);
        logic signed [ROW_W-1:0] c;
        c = '0;
        case (idx)
            4'd0: c = 21'sd1;
            4'd1: c = 21'sd2;
            4'd2: c = 21'sd3;
            4'd3: c = 21'sd4;
            4'd4: c = 21'sd5;
            4'd5: c = 21'sd6;
            4'd6: c = 21'sd7;
            4'd7: c = 21'sd8;
            4'd8: c = 21'sd9;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/vector_norm_max_select_core.sv @@
// Top level of the vector norm maximum selector: config register, result
// register and the controller/datapath pair. Depends on vnms_pkg.
//
// Usage: each s_ beat carries one signed 3-element vector; s_tlast marks the
// last vector of a set. The norm is picked by norm_kind on the cfg_ channel
// (0 largest absolute element, 1 sum of squares, 2 or 3 quadratic form with
// the matrix 1..9), sampled when a vector is taken. On the last vector one
// m_ beat gives the maximum, the tie mask, the tie count and the overflow flag.
// Timing: a vector is taken, then worked on through one shared multiplier:
// the largest element directly, three squares plus drain or twelve
// multiplies plus drain, then an update. A new vector is taken only after
// that update; the result is valid the cycle after the update.
// A held result does not block the next set; only the last vector of the next
// set waits in its update cycle until the result register is free.
// Reset: norm_kind returns to sum of squares, the set is cleared and no
// result is pending. cfg_ready is always high.
module vector_norm_max_select_core #(
    parameter int VECTOR_SLOTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // cfg_data: norm_kind[1:0]
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_data,
    // s_tdata: elem_first[15:0], elem_second[31:16], elem_third[47:32]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vnms_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    // m_tdata: max_value[36:0], tie_mask[52:37], tie_count[57:53], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vnms_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: overflow[0]
    output logic [0:0]                         m_tuser
);

    localparam int MASK_LIMIT = (VECTOR_SLOTS < vnms_pkg::MASK_W) ? VECTOR_SLOTS
                                                                  : vnms_pkg::MASK_W;

    logic [1:0]                              norm_kind_reg;
    logic                                    m_tvalid_reg;
    logic [vnms_pkg::M_TDATA_W-1:0]          m_tdata_reg;
    logic                                    m_tuser_reg;
    logic                                    out_full;
    vnms_pkg::dp_cmd_t                       cmd;
    logic signed [vnms_pkg::VALUE_W-1:0]     res_value;
    logic [vnms_pkg::MASK_W-1:0]             res_mask;
    logic [vnms_pkg::COUNT_W-1:0]            res_count;
    logic                                    res_overflow;

    assign cfg_ready = 1'b1;
    assign out_full  = m_tvalid_reg && !m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_kind_reg <= vnms_pkg::NORM_SUMSQ;
        end else if (cfg_valid) begin
            norm_kind_reg <= cfg_data;
        end
    end

    vnms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tlast   (s_tlast),
        .norm_kind (norm_kind_reg),
        .out_full  (out_full),
        .cmd       (cmd)
    );

    vnms_datapath #(
        .MASK_LIMIT (MASK_LIMIT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_elems     (s_tdata),
        .res_value    (res_value),
        .res_mask     (res_mask),
        .res_count    (res_count),
        .res_overflow (res_overflow)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {{vnms_pkg::M_PAD_W{1'b0}}, res_count, res_mask, res_value};
            m_tuser_reg <= res_overflow;
        end
    end

    // a result is never loaded over one still waiting downstream
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !out_full)
        else $error("result loaded while output register stalled");

    // one vector at a time: no beat accepted straight after another
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a vector is in progress");

    // tie count always agrees with the mask it was built alongside
    a_tie_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones(m_tdata[52:37]) == m_tdata[57:53]))
        else $error("tie count does not match tie mask");

    // loading, multiplying and updating never overlap
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.mul_en, cmd.update}))
        else $error("conflicting datapath commands");

endmodule

@@ rtl/vnms_ctrl.sv @@
// Sequencer for the vector norm maximum selector: accepts beats and steps
// the shared multiplier. Depends on vnms_pkg for the command struct.
module vnms_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tlast,
    input  logic [1:0]           norm_kind,
    input  logic                 out_full,
    output vnms_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_CALC   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [vnms_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [1:0]                      kind_reg, kind_next;
    logic                            last_reg, last_next;
    logic [vnms_pkg::STEP_W-1:0]     n_steps;
    logic                            is_form;

    assign is_form = (kind_reg == vnms_pkg::NORM_FORM) || (kind_reg == vnms_pkg::NORM_SPARE);
    assign n_steps = (kind_reg == vnms_pkg::NORM_MAXABS) ? vnms_pkg::STEPS_MAXABS :
                     (kind_reg == vnms_pkg::NORM_SUMSQ)  ? vnms_pkg::STEPS_SUMSQ  :
                                                           vnms_pkg::STEPS_FORM;
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            kind_reg  <= vnms_pkg::NORM_SUMSQ;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            kind_reg  <= kind_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.check_sign = is_form;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    kind_next  = norm_kind;
                    last_next  = s_tlast;
                    step_next  = '0;
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (step_reg == n_steps) begin
                    // last product drains into the value this cycle, or the largest absolute element is loaded
                    cmd.abs_en = (kind_reg == vnms_pkg::NORM_MAXABS);
                    state_next = S_UPDATE;
                end else begin
                    cmd.mul_en = 1'b1;
                    step_next  = step_reg + 4'd1;
                    if (!is_form) begin
                        cmd.a_src  = vnms_pkg::A_ELEM;
                        cmd.b_elem = step_reg[1:0];
                        cmd.dst    = vnms_pkg::DST_VAL;
                    end else begin
                        cmd.a_src    = vnms_pkg::A_COEF;
                        cmd.coef_idx = step_reg;
                        unique case (step_reg)
                            4'd0: begin cmd.b_elem = 2'd0; cmd.dst = vnms_pkg::DST_ROW0; end
                            4'd1: begin cmd.b_elem = 2'd1; cmd.dst = vnms_pkg::DST_ROW0; end
                            4'd2: begin cmd.b_elem = 2'd2; cmd.dst = vnms_pkg::DST_ROW0; end
                            4'd3: begin cmd.b_elem = 2'd0; cmd.dst = vnms_pkg::DST_ROW1; end
                            4'd4: begin cmd.b_elem = 2'd1; cmd.dst = vnms_pkg::DST_ROW1; end
                            4'd5: begin cmd.b_elem = 2'd2; cmd.dst = vnms_pkg::DST_ROW1; end
                            4'd6: begin cmd.b_elem = 2'd0; cmd.dst = vnms_pkg::DST_ROW2; end
                            4'd7: begin cmd.b_elem = 2'd1; cmd.dst = vnms_pkg::DST_ROW2; end
                            4'd8: begin cmd.b_elem = 2'd2; cmd.dst = vnms_pkg::DST_ROW2; end
                            // rows are complete by the time each is multiplied back
                            4'd9: begin
                                cmd.a_src = vnms_pkg::A_ROW; cmd.a_row = 2'd0;
                                cmd.b_elem = 2'd0; cmd.dst = vnms_pkg::DST_VAL;
                            end
                            4'd10: begin
                                cmd.a_src = vnms_pkg::A_ROW; cmd.a_row = 2'd1;
                                cmd.b_elem = 2'd1; cmd.dst = vnms_pkg::DST_VAL;
                            end
                            4'd11: begin
                                cmd.a_src = vnms_pkg::A_ROW; cmd.a_row = 2'd2;
                                cmd.b_elem = 2'd2; cmd.dst = vnms_pkg::DST_VAL;
                            end
                            default: cmd.mul_en = 1'b0;
                        endcase
                    end
                end
            end
            S_UPDATE: begin
                // the last vector of a set holds while a finished result still waits downstream
                if (!(last_reg && out_full)) begin
                    cmd.update = 1'b1;
                    cmd.emit   = last_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ rtl/vnms_datapath.sv @@
// Datapath for the vector norm maximum selector: shared multiplier,
// accumulators and running maximum with tie mask. Depends on vnms_pkg.
module vnms_datapath #(
    parameter int MASK_LIMIT = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  vnms_pkg::dp_cmd_t                     cmd,
    input  logic [vnms_pkg::S_TDATA_W-1:0]        in_elems,
    output logic signed [vnms_pkg::VALUE_W-1:0]   res_value,
    output logic [vnms_pkg::MASK_W-1:0]           res_mask,
    output logic [vnms_pkg::COUNT_W-1:0]          res_count,
    output logic                                  res_overflow
);

    localparam int EW = vnms_pkg::ELEM_W;
    localparam int RW = vnms_pkg::ROW_W;
    localparam int VW = vnms_pkg::VALUE_W;
    localparam int MW = vnms_pkg::MASK_W;
    localparam int CW = vnms_pkg::COUNT_W;

    logic signed [EW-1:0]  x_reg [3];
    logic signed [RW-1:0]  row_reg [3];
    logic signed [VW-1:0]  val_reg;
    logic signed [VW-1:0]  prod_reg;
    vnms_pkg::acc_dst_t    prod_dst_reg;
    logic                  prod_valid_reg;

    logic signed [VW-1:0]  best_reg, best_next;
    logic [MW-1:0]         mask_reg, mask_next;
    logic [CW-1:0]         tie_reg, tie_next;
    logic [CW-1:0]         vcount_reg, vcount_next;
    logic                  have_reg, have_next;
    logic                  ovf_reg, ovf_next;

    logic signed [RW-1:0]  op_a;
    logic signed [EW-1:0]  op_b;
    logic signed [VW-1:0]  prod;
    logic [EW:0]           abs_v [3];
    logic [EW:0]           abs_max;
    logic                  in_range, candidate;
    logic [MW-1:0]         idx_bit;

    // operand selection for the shared multiplier
    always_comb begin
        case (cmd.b_elem)
            2'd0:    op_b = x_reg[0];
            2'd1:    op_b = x_reg[1];
            2'd2:    op_b = x_reg[2];
            default: op_b = '0;
        endcase
        case (cmd.a_src)
            vnms_pkg::A_COEF: op_a = vnms_pkg::form_coef(cmd.coef_idx);
            vnms_pkg::A_ROW: begin
                case (cmd.a_row)
                    2'd0:    op_a = row_reg[0];
                    2'd1:    op_a = row_reg[1];
                    2'd2:    op_a = row_reg[2];
                    default: op_a = '0;
                endcase
            end
            vnms_pkg::A_ELEM: op_a = {{(RW-EW){op_b[EW-1]}}, op_b};
            default:          op_a = '0;
        endcase
    end

    assign prod = op_a * op_b;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_v[i] = x_reg[i][EW-1] ? ((EW+1)'(0) - {1'b1, x_reg[i]}) : {1'b0, x_reg[i]};
        end
        abs_max = abs_v[0];
        if (abs_v[1] > abs_max) abs_max = abs_v[1];
        if (abs_v[2] > abs_max) abs_max = abs_v[2];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg[0] <= in_elems[EW-1:0];
            x_reg[1] <= in_elems[2*EW-1:EW];
            x_reg[2] <= in_elems[3*EW-1:2*EW];
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
            val_reg    <= '0;
        end else if (cmd.abs_en) begin
            val_reg <= {{(VW-EW-1){1'b0}}, abs_max};
        end else if (prod_valid_reg) begin
            case (prod_dst_reg)
                vnms_pkg::DST_ROW0: row_reg[0] <= row_reg[0] + prod_reg[RW-1:0];
                vnms_pkg::DST_ROW1: row_reg[1] <= row_reg[1] + prod_reg[RW-1:0];
                vnms_pkg::DST_ROW2: row_reg[2] <= row_reg[2] + prod_reg[RW-1:0];
                default:            val_reg    <= val_reg + prod_reg;
            endcase
        end
        prod_reg     <= prod;
        prod_dst_reg <= cmd.dst;
    end

    // running maximum and tie tracking
    assign in_range  = (vcount_reg < CW'(MASK_LIMIT));
    assign idx_bit   = in_range ? (MW'(1) << vcount_reg[3:0]) : '0;
    assign candidate = !(cmd.check_sign && val_reg[VW-1]);

    always_comb begin
        best_next   = best_reg;
        mask_next   = mask_reg;
        tie_next    = tie_reg;
        have_next   = have_reg;
        ovf_next    = ovf_reg | !in_range;
        vcount_next = (vcount_reg != vnms_pkg::COUNT_SAT) ? vcount_reg + CW'(1) : vcount_reg;
        if (candidate) begin
            if (!have_reg || (val_reg > best_reg)) begin
                best_next = val_reg;
                mask_next = idx_bit;
                tie_next  = CW'(in_range);
                have_next = 1'b1;
            end else if (val_reg == best_reg) begin
                mask_next = mask_reg | idx_bit;
                tie_next  = tie_reg + CW'(in_range);
            end
        end
    end

    assign res_value    = best_next;
    assign res_mask     = mask_next;
    assign res_count    = tie_next;
    assign res_overflow = ovf_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            best_reg       <= '0;
            mask_reg       <= '0;
            tie_reg        <= '0;
            vcount_reg     <= '0;
            have_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
        end else begin
            prod_valid_reg <= cmd.mul_en;
            if (cmd.emit) begin
                // start a fresh set
                best_reg   <= '0;
                mask_reg   <= '0;
                tie_reg    <= '0;
                vcount_reg <= '0;
                have_reg   <= 1'b0;
                ovf_reg    <= 1'b0;
            end else if (cmd.update) begin
                best_reg   <= best_next;
                mask_reg   <= mask_next;
                tie_reg    <= tie_next;
                vcount_reg <= vcount_next;
                have_reg   <= have_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule
